// File: hdl/mtrr_pkg.sv
// Shared types, constants and the fixed range selector for the MTRR memory type lookup block.
`timescale 1ns / 1ps
`default_nettype none
package mtrr_pkg;

    localparam logic [1:0] FUNC_LOOKUP    = 2'd0;
    localparam logic [1:0] FUNC_WR_FIXED  = 2'd1;
    localparam logic [1:0] FUNC_WR_BASE   = 2'd2;
    localparam logic [1:0] FUNC_WR_MASK   = 2'd3;

    localparam logic [2:0] CFG_MTRR_ON    = 3'd0;
    localparam logic [2:0] CFG_FIXED_SUP  = 3'd1;
    localparam logic [2:0] CFG_FIXED_ON   = 3'd2;
    localparam logic [2:0] CFG_VAR_COUNT  = 3'd3;
    localparam logic [2:0] CFG_DEF_TYPE   = 3'd4;

    localparam logic [1:0] FROM_DISABLED  = 2'd0;
    localparam logic [1:0] FROM_FIXED     = 2'd1;
    localparam logic [1:0] FROM_VARIABLE  = 2'd2;
    localparam logic [1:0] FROM_DEFAULT   = 2'd3;

    localparam logic [7:0] TYPE_UC        = 8'd0;
    localparam logic [7:0] TYPE_WT        = 8'd4;
    localparam logic [7:0] TYPE_WB        = 8'd6;

    localparam int         FIXED_WORDS    = 11;
    localparam logic [63:0] LOW_MEG_END   = 64'h10_0000;
    localparam logic [63:0] REGION16K     = 64'h08_0000;
    localparam logic [63:0] REGION4K      = 64'h0C_0000;
    localparam logic [63:0] PAGE_MASK     = 64'hFFF;
    localparam int         VALID_BIT      = 11;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_TEST  = 3'b100
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] mtype;
    } match_t;

    typedef struct packed {
        logic [3:0] word;
        logic [2:0] byte_sel;
    } fixed_sel_t;

    function automatic fixed_sel_t fixed_pick(input logic [63:0] addr);
        fixed_sel_t sel;
        if (addr < REGION16K) begin
            sel.word     = 4'd0;
            sel.byte_sel = addr[18:16];
        end else if (addr < REGION4K) begin
            sel.word     = 4'd1 + {3'd0, addr[17]};
            sel.byte_sel = addr[16:14];
        end else begin
            sel.word     = 4'd3 + {1'b0, addr[17:15]};
            sel.byte_sel = addr[14:12];
        end
        return sel;
    endfunction

endpackage
`default_nettype wire

// File: hdl/mtrr_memory_type_lookup_core.sv
// Top level of the MTRR memory type lookup block: stores, sequencer, result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_func, s_slot, s_reg_value, s_phys_address
//  m_      | out       | m_valid / m_ready  | m_memory_type, m_matched_from
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A lookup answered by the enable, the fixed table or an empty pair count has its result
// registered in the cycle after acceptance; a variable walk examines the pairs in turn,
// each with a pair RAM read (ST_FETCH) and then one pass of the shared compare unit
// (ST_TEST), and ends early on UC.
// Reset clears the config registers, the fixed words and the pair valid bits.
// s_ready is low during a walk and while a result waits on m_ready.
`timescale 1ns / 1ps
`default_nettype none
module mtrr_memory_type_lookup_core #(
    parameter int VARIABLE_PAIRS = 8,
    parameter int ADDRESS_BITS   = 52
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [3:0]  s_slot,
    input  wire logic [63:0] s_reg_value,
    input  wire logic [51:0] s_phys_address,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_memory_type,
    output logic [1:0]       m_matched_from,

    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wr_data
);
    import mtrr_pkg::*;

    localparam int AW = (VARIABLE_PAIRS > 1) ? $clog2(VARIABLE_PAIRS) : 1;
    localparam int SW = (AW > 4) ? AW : 4;
    localparam logic [63:0] ADDR_LIMIT =
        (ADDRESS_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDRESS_BITS) - 64'd1);

    logic        mtrr_on_reg;
    logic        fixed_sup_reg;
    logic        fixed_on_reg;
    logic [3:0]  var_count_reg;
    logic [7:0]  def_type_reg;

    logic [63:0] fixed_reg [FIXED_WORDS];
    logic [VARIABLE_PAIRS-1:0] base_vld_reg;
    logic [VARIABLE_PAIRS-1:0] mask_vld_reg;

    state_t      state_reg, state_next;
    logic [63:0] addr_reg, addr_next;
    logic [3:0]  count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        have_reg, have_next;
    logic [7:0]  kept_reg, kept_next;
    logic        rd_bvld_reg, rd_mvld_reg;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_type_reg, m_type_next;
    logic [1:0]  m_from_reg, m_from_next;

    logic        accept;
    logic [63:0] s_addr;
    logic [SW-1:0] slot_ext;
    logic        slot_var_ok;
    logic        slot_fix_ok;
    logic        base_we, mask_we;
    logic [63:0] base_raw, mask_raw, base_eff, mask_eff;
    match_t      hit;
    fixed_sel_t  fsel;
    logic [7:0]  fixed_byte;
    logic [3:0]  count_clamp;
    logic        last_pair;

    assign s_ready        = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_memory_type  = m_type_reg;
    assign m_matched_from = m_from_reg;

    assign s_addr      = {12'd0, s_phys_address} & ADDR_LIMIT;
    assign slot_ext    = SW'(s_slot);
    assign slot_var_ok = (32'(s_slot) < 32'(VARIABLE_PAIRS));
    assign slot_fix_ok = (32'(s_slot) < 32'(FIXED_WORDS));
    assign base_we     = accept && (s_func == FUNC_WR_BASE) && slot_var_ok;
    assign mask_we     = accept && (s_func == FUNC_WR_MASK) && slot_var_ok;

    assign count_clamp = (32'(var_count_reg) > 32'(VARIABLE_PAIRS)) ?
                         4'(VARIABLE_PAIRS) : var_count_reg;

    assign fsel       = fixed_pick(s_addr);
    assign fixed_byte = 8'(fixed_reg[fsel.word] >> {fsel.byte_sel, 3'b000});

    mtrr_ram #(.WIDTH(64), .DEPTH(VARIABLE_PAIRS)) u_base_ram (
        .aclk    (aclk),
        .wr_en   (base_we),
        .wr_addr (slot_ext[AW-1:0]),
        .wr_data (s_reg_value),
        .rd_addr (idx_reg),
        .rd_data (base_raw)
    );

    mtrr_ram #(.WIDTH(64), .DEPTH(VARIABLE_PAIRS)) u_mask_ram (
        .aclk    (aclk),
        .wr_en   (mask_we),
        .wr_addr (slot_ext[AW-1:0]),
        .wr_data (s_reg_value),
        .rd_addr (idx_reg),
        .rd_data (mask_raw)
    );

    assign base_eff = rd_bvld_reg ? base_raw : 64'd0;
    assign mask_eff = rd_mvld_reg ? mask_raw : 64'd0;

    mtrr_match #(.ADDRESS_BITS(ADDRESS_BITS)) u_match (
        .addr   (addr_reg),
        .base   (base_eff),
        .mask   (mask_eff),
        .result (hit)
    );

    assign last_pair = ((32'(idx_reg) + 32'd1) == 32'(count_reg));

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        have_next    = have_reg;
        kept_next    = kept_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_type_next  = m_type_reg;
        m_from_next  = m_from_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_func == FUNC_LOOKUP)) begin
                    addr_next  = s_addr;
                    count_next = count_clamp;
                    idx_next   = '0;
                    have_next  = 1'b0;
                    if (!mtrr_on_reg) begin
                        m_valid_next = 1'b1;
                        m_type_next  = TYPE_UC;
                        m_from_next  = FROM_DISABLED;
                    end else if ((s_addr < LOW_MEG_END) && fixed_sup_reg && fixed_on_reg) begin
                        m_valid_next = 1'b1;
                        m_type_next  = fixed_byte;
                        m_from_next  = FROM_FIXED;
                    end else if (count_clamp == 4'd0) begin
                        m_valid_next = 1'b1;
                        m_type_next  = def_type_reg;
                        m_from_next  = FROM_DEFAULT;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (hit.hit && (hit.mtype == TYPE_UC)) begin
                    m_valid_next = 1'b1;
                    m_type_next  = TYPE_UC;
                    m_from_next  = FROM_VARIABLE;
                    state_next   = ST_IDLE;
                end else begin
                    if (hit.hit && !have_reg) begin
                        have_next = 1'b1;
                        kept_next = hit.mtype;
                    end else if (hit.hit && (kept_reg == TYPE_WB) && (hit.mtype == TYPE_WT)) begin
                        kept_next = TYPE_WT;
                    end
                    if (last_pair) begin
                        m_valid_next = 1'b1;
                        m_type_next  = have_next ? kept_next : def_type_reg;
                        m_from_next  = have_next ? FROM_VARIABLE : FROM_DEFAULT;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            mtrr_on_reg   <= 1'b0;
            fixed_sup_reg <= 1'b0;
            fixed_on_reg  <= 1'b0;
            var_count_reg <= 4'd0;
            def_type_reg  <= 8'd0;
            base_vld_reg  <= '0;
            mask_vld_reg  <= '0;
            for (int i = 0; i < FIXED_WORDS; i++) begin
                fixed_reg[i] <= 64'd0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MTRR_ON:   mtrr_on_reg   <= cfg_wr_data[0];
                    CFG_FIXED_SUP: fixed_sup_reg <= cfg_wr_data[0];
                    CFG_FIXED_ON:  fixed_on_reg  <= cfg_wr_data[0];
                    CFG_VAR_COUNT: var_count_reg <= cfg_wr_data[3:0];
                    CFG_DEF_TYPE:  def_type_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept && (s_func == FUNC_WR_FIXED) && slot_fix_ok) begin
                fixed_reg[s_slot] <= s_reg_value;
            end
            if (base_we) begin
                base_vld_reg[slot_ext[AW-1:0]] <= 1'b1;
            end
            if (mask_we) begin
                mask_vld_reg[slot_ext[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        count_reg   <= count_next;
        idx_reg     <= idx_next;
        have_reg    <= have_next;
        kept_reg    <= kept_next;
        m_type_reg  <= m_type_next;
        m_from_reg  <= m_from_next;
        rd_bvld_reg <= base_vld_reg[idx_reg];
        rd_mvld_reg <= mask_vld_reg[idx_reg];
    end

endmodule
`default_nettype wire

// File: hdl/mtrr_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mtrr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

// File: hdl/mtrr_match.sv
// Shared variable range compare unit: masked address match and type extract.
`timescale 1ns / 1ps
`default_nettype none
module mtrr_match #(
    parameter int ADDRESS_BITS = 52
) (
    input  wire logic [63:0]       addr,
    input  wire logic [63:0]       base,
    input  wire logic [63:0]       mask,
    output mtrr_pkg::match_t       result
);
    import mtrr_pkg::*;

    localparam logic [63:0] ADDR_LIMIT =
        (ADDRESS_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [63:0] cmp_mask;

    assign cmp_mask     = mask & ~PAGE_MASK & ADDR_LIMIT;
    assign result.hit   = mask[VALID_BIT] && (((addr ^ base) & cmp_mask) == 64'd0);
    assign result.mtype = base[7:0];

endmodule
`default_nettype wire
